@@ sv/tads_pkg.sv @@
package tads_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned BandW  = 15;
    localparam int unsigned CfgIdxW = 3;

    // configuration register map
    typedef enum logic [CfgIdxW-1:0] {
        REG_TARGET_X = 3'd0,
        REG_TARGET_Y = 3'd1,
        REG_TARGET_Z = 3'd2,
        REG_BAND_XY  = 3'd3,
        REG_BAND_Z   = 3'd4,
        REG_PARK_X   = 3'd5,
        REG_PARK_Y   = 3'd6,
        REG_PARK_Z   = 3'd7
    } cfg_idx_t;

    // phase codes
    typedef enum logic [1:0] {
        PHASE_X = 2'd0,
        PHASE_Y = 2'd1,
        PHASE_Z = 2'd2
    } phase_t;

    localparam logic [CoordW-1:0] TargetXRst = 16'h0160;
    localparam logic [CoordW-1:0] TargetYRst = 16'h0160;
    localparam logic [CoordW-1:0] TargetZRst = 16'h1800;
    localparam logic [BandW-1:0]  BandXyRst  = 15'h0010;
    localparam logic [BandW-1:0]  BandZRst   = 15'h0100;
    localparam logic [CoordW-1:0] ParkXRst   = 16'd252;
    localparam logic [CoordW-1:0] ParkYRst   = 16'd5144;
    localparam logic [CoordW-1:0] ParkZRst   = 16'd0;

    typedef struct packed {
        logic              limit_hit;
        logic [CoordW-1:0] pos_z;
        logic [CoordW-1:0] pos_y;
        logic [CoordW-1:0] pos_x;
    } report_t;

    typedef struct packed {
        phase_t phase;
        logic   run_z;
        logic   dir_z;
        logic   run_xy;
        logic   dir_b;
        logic   dir_a;
        logic   all_parked;
    } result_t;

    // error of one axis is below zero
    function automatic logic err_neg(input logic [CoordW-1:0] err);
        return err[CoordW-1];
    endfunction

    // error of one axis is above its deadband
    function automatic logic err_above(input logic [CoordW-1:0] err,
                                       input logic [BandW-1:0]  band);
        return !err[CoordW-1] && (err[CoordW-2:0] > band);
    endfunction

endpackage

@@ sv/three_axis_deadband_sequencer_top.sv @@
// channel   | ports                              | transaction
// ----------+------------------------------------+---------------------------------
// report in | s_tvalid s_tready s_tdata[55:0]    | one position report
// result    | m_tvalid m_tready m_tdata[7:0]     | one set of motor controls
// config    | cfg_valid cfg_ready cfg_index cfg_data | one register write
//
// two stages: an input register holds the report, and the sequencing logic
// feeds the result register, updating the axis state as it does
// one report per cycle sustained while m_tready is high
// both stages move whenever the result register is empty or being taken,
// so a stall on the result side holds one result and one report, then drops s_tready
// reset (synchronous, active low) clears valids and axis state and sets the configuration
// registers to their defaults; cfg_ready is always high
module three_axis_deadband_sequencer_top
    import tads_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], limit_hit[48], zero fill
    input  logic [55:0]         s_tdata,

    output logic                m_tvalid,
    input  logic                m_tready,
    // all_parked, dir_a, dir_b, run_xy, dir_z, run_z, phase[7:6]
    output logic [7:0]          m_tdata,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CoordW-1:0]   cfg_data
);

    // configuration registers
    logic [CoordW-1:0] target_x_reg, target_y_reg, target_z_reg;
    logic [BandW-1:0]  band_xy_reg, band_z_reg;
    logic [CoordW-1:0] park_x_reg, park_y_reg, park_z_reg;

    // pipeline
    logic    in_valid_reg;
    report_t in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    advance;

    // axis state
    logic y_active_reg, z_active_reg, limit_latch_reg;
    logic dir_a_reg, dir_b_reg, dir_z_reg, run_xy_reg, run_z_reg;
    logic y_active_next, z_active_next, limit_latch_next;
    logic dir_a_next, dir_b_next, dir_z_next, run_xy_next, run_z_next;
    result_t out_data_next;

    logic [CoordW-1:0] err_x, err_y, err_z;
    logic at_park_x, at_park_y, at_park_z;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // wrapped 16 bit errors, read as two's complement
    assign err_x = target_x_reg - in_data_reg.pos_x;
    assign err_y = target_y_reg - in_data_reg.pos_y;
    assign err_z = target_z_reg - in_data_reg.pos_z;

    assign at_park_x = (in_data_reg.pos_x == park_x_reg);
    assign at_park_y = (in_data_reg.pos_y == park_y_reg);
    assign at_park_z = (in_data_reg.pos_z == park_z_reg);

    always_comb begin
        y_active_next    = y_active_reg;
        z_active_next    = z_active_reg;
        limit_latch_next = limit_latch_reg;
        dir_a_next       = dir_a_reg;
        dir_b_next       = dir_b_reg;
        dir_z_next       = dir_z_reg;
        run_xy_next      = run_xy_reg;
        run_z_next       = run_z_reg;

        // x stage, driven on every report
        if (!at_park_x) begin
            if (err_neg(err_x)) begin
                dir_a_next  = 1'b0;
                dir_b_next  = 1'b0;
                run_xy_next = 1'b1;
            end else if (err_above(err_x, band_xy_reg)) begin
                dir_a_next  = 1'b1;
                dir_b_next  = 1'b1;
                run_xy_next = 1'b1;
            end else begin
                y_active_next = 1'b1;
                run_xy_next   = 1'b0;
            end
        end else begin
            run_xy_next   = 1'b0;
            y_active_next = 1'b1;
        end

        // y stage, when active and not at park, overrides the planar controls of the x stage
        if (y_active_next) begin
            if (!at_park_y) begin
                if (err_neg(err_y)) begin
                    dir_a_next  = 1'b0;
                    dir_b_next  = 1'b1;
                    run_xy_next = 1'b1;
                end else if (err_above(err_y, band_xy_reg)) begin
                    dir_a_next  = 1'b1;
                    dir_b_next  = 1'b0;
                    run_xy_next = 1'b1;
                end else begin
                    y_active_next = 1'b0;
                    z_active_next = 1'b1;
                    run_xy_next   = 1'b0;
                end
            end else begin
                // planar run left as it is
                y_active_next = 1'b0;
                z_active_next = 1'b1;
            end
        end

        if (in_data_reg.limit_hit) begin
            limit_latch_next = 1'b1;
        end

        // z stage
        if (z_active_next) begin
            if (!at_park_z) begin
                limit_latch_next = 1'b0;
                if (err_neg(err_z)) begin
                    dir_z_next = 1'b1;
                    run_z_next = 1'b1;
                end else if (err_above(err_z, band_z_reg)) begin
                    dir_z_next = 1'b0;
                    run_z_next = 1'b1;
                end else begin
                    z_active_next = 1'b0;
                    run_z_next    = 1'b0;
                end
            end else if (limit_latch_next) begin
                run_z_next = 1'b0;
            end else begin
                dir_z_next = 1'b1;
                run_z_next = 1'b1;
            end
        end

        out_data_next.all_parked = at_park_x && at_park_y && at_park_z;
        out_data_next.dir_a      = dir_a_next;
        out_data_next.dir_b      = dir_b_next;
        out_data_next.run_xy     = run_xy_next;
        out_data_next.dir_z      = dir_z_next;
        out_data_next.run_z      = run_z_next;
        if (z_active_next) begin
            out_data_next.phase = PHASE_Z;
        end else if (y_active_next) begin
            out_data_next.phase = PHASE_Y;
        end else begin
            out_data_next.phase = PHASE_X;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg <= TargetXRst;
            target_y_reg <= TargetYRst;
            target_z_reg <= TargetZRst;
            band_xy_reg  <= BandXyRst;
            band_z_reg   <= BandZRst;
            park_x_reg   <= ParkXRst;
            park_y_reg   <= ParkYRst;
            park_z_reg   <= ParkZRst;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TARGET_X: target_x_reg <= cfg_data;
                REG_TARGET_Y: target_y_reg <= cfg_data;
                REG_TARGET_Z: target_z_reg <= cfg_data;
                REG_BAND_XY:  band_xy_reg  <= cfg_data[BandW-1:0];
                REG_BAND_Z:   band_z_reg   <= cfg_data[BandW-1:0];
                REG_PARK_X:   park_x_reg   <= cfg_data;
                REG_PARK_Y:   park_y_reg   <= cfg_data;
                REG_PARK_Z:   park_z_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register, payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= report_t'(s_tdata[$bits(report_t)-1:0]);
        end
    end

    // result register and axis state move together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            y_active_reg    <= 1'b0;
            z_active_reg    <= 1'b0;
            limit_latch_reg <= 1'b0;
            dir_a_reg       <= 1'b0;
            dir_b_reg       <= 1'b0;
            dir_z_reg       <= 1'b0;
            run_xy_reg      <= 1'b0;
            run_z_reg       <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                y_active_reg    <= y_active_next;
                z_active_reg    <= z_active_next;
                limit_latch_reg <= limit_latch_next;
                dir_a_reg       <= dir_a_next;
                dir_b_reg       <= dir_b_next;
                dir_z_reg       <= dir_z_next;
                run_xy_reg      <= run_xy_next;
                run_z_reg       <= run_z_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    // axis state only moves when a report passes into the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_valid_reg) |=>
            $stable({y_active_reg, z_active_reg, limit_latch_reg, run_xy_reg, run_z_reg}))
        else $error("axis state changed without a report");

    // a parked report can never leave the planar drives running
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.all_parked |-> !out_data_reg.run_xy)
        else $error("planar drive running at park");

    // the unused phase code never reaches the result channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg.phase != 2'd3)
        else $error("illegal phase code");

    // nothing is shown on the result side just after reset
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule
